[rtl/assert_macros.svh]
// Assertion macros used by the top level of the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define CLE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CLE_ASSERT(label, clk, rst_n, prop, msg)
`define CLE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

[rtl/clist_pkg.sv]
// Types, codes and pointer helpers of the circular list engine.
package clist_pkg;

	localparam int CAPACITY = 16;
	localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	// command codes
	localparam logic [1:0] FN_INS_END = 2'd0;
	localparam logic [1:0] FN_INS_BEG = 2'd1;
	localparam logic [1:0] FN_DELETE  = 2'd2;
	localparam logic [1:0] FN_DISPLAY = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} ctrl_stat_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CAPACITY - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(CAPACITY - 1) : PTR_W'(p - 1'b1);
	endfunction

endpackage

[rtl/clist_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module clist_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/clist_ctrl.sv]
// Command sequencer: head/tail/count, search, compaction and display walk.
module clist_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  clist_pkg::cmd_t                 cmd,
	input  logic                            slot_free,
	output logic                            res_load,
	output clist_pkg::res_t                 res_d,
	output clist_pkg::mem_req_t             mreq,
	input  logic [clist_pkg::DATA_W-1:0]    rdata,
	output clist_pkg::ctrl_stat_t           stat
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SRCH  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DISP  = 4'b1000
	} state_t;

	state_t                          state_q, state_d;
	logic [clist_pkg::PTR_W-1:0]     head_q, head_d;
	logic [clist_pkg::PTR_W-1:0]     tail_q, tail_d;
	logic [clist_pkg::CNT_W-1:0]     count_q, count_d;
	logic [clist_pkg::PTR_W-1:0]     cur_q, cur_d;    // position of the word in rdata
	logic [clist_pkg::CNT_W-1:0]     idx_q, idx_d;    // list index of the word in rdata
	logic [clist_pkg::DATA_W-1:0]    key_q, key_d;
	logic                            accept;
	logic                            full;
	logic                            empty;
	logic                            hit;
	logic                            last_one;

	assign accept   = (state_q == S_IDLE) && cmd_valid && slot_free;
	assign cmd_stall = !((state_q == S_IDLE) && slot_free);
	assign full     = (count_q == clist_pkg::CNT_W'(clist_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign hit      = (rdata == key_q);
	assign last_one = (clist_pkg::CNT_W'(idx_q + 1'b1) == count_q);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		cur_d    = cur_q;
		idx_d    = idx_q;
		key_d    = key_q;
		mreq     = '0;
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load    = 1'b1;
					res_d.last  = 1'b1;
					case (cmd.func)
						clist_pkg::FN_INS_END: begin
							if (full) begin
								res_d.status = clist_pkg::ST_FULL;
							end else begin
								mreq.we    = 1'b1;
								mreq.waddr = tail_q;
								mreq.wdata = cmd.value;
								tail_d     = clist_pkg::ptr_inc(tail_q);
								count_d    = clist_pkg::CNT_W'(count_q + 1'b1);
								res_d.status = clist_pkg::ST_OK;
							end
						end
						clist_pkg::FN_INS_BEG: begin
							if (full) begin
								res_d.status = clist_pkg::ST_FULL;
							end else begin
								mreq.we    = 1'b1;
								mreq.waddr = clist_pkg::ptr_dec(head_q);
								mreq.wdata = cmd.value;
								head_d     = clist_pkg::ptr_dec(head_q);
								count_d    = clist_pkg::CNT_W'(count_q + 1'b1);
								res_d.status = clist_pkg::ST_OK;
							end
						end
						default: begin
							// delete and display both start by reading the head
							if (empty) begin
								res_d.status = clist_pkg::ST_EMPTY;
							end else begin
								res_load   = 1'b0;
								res_d      = '0;
								mreq.re    = 1'b1;
								mreq.raddr = head_q;
								cur_d      = head_q;
								idx_d      = '0;
								key_d      = cmd.value;
								state_d    = (cmd.func == clist_pkg::FN_DELETE) ? S_SRCH : S_DISP;
							end
						end
					endcase
				end
			end
			S_SRCH: begin
				if (slot_free) begin
					if (hit && last_one) begin
						// hit on the tail entry: just drop it
						tail_d       = clist_pkg::ptr_dec(tail_q);
						count_d      = clist_pkg::CNT_W'(count_q - 1'b1);
						res_load     = 1'b1;
						res_d.status = clist_pkg::ST_OK;
						res_d.last   = 1'b1;
						state_d      = S_IDLE;
					end else if (!hit && last_one) begin
						res_load     = 1'b1;
						res_d.status = clist_pkg::ST_NOT_FOUND;
						res_d.last   = 1'b1;
						state_d      = S_IDLE;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = clist_pkg::ptr_inc(cur_q);
						cur_d      = clist_pkg::ptr_inc(cur_q);
						idx_d      = clist_pkg::CNT_W'(idx_q + 1'b1);
						if (hit) begin
							state_d = S_SHIFT;
						end
					end
				end
			end
			S_SHIFT: begin
				if (slot_free) begin
					// move the entry one place toward the head
					mreq.we    = 1'b1;
					mreq.waddr = clist_pkg::ptr_dec(cur_q);
					mreq.wdata = rdata;
					if (last_one) begin
						tail_d       = clist_pkg::ptr_dec(tail_q);
						count_d      = clist_pkg::CNT_W'(count_q - 1'b1);
						res_load     = 1'b1;
						res_d.status = clist_pkg::ST_OK;
						res_d.last   = 1'b1;
						state_d      = S_IDLE;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = clist_pkg::ptr_inc(cur_q);
						cur_d      = clist_pkg::ptr_inc(cur_q);
						idx_d      = clist_pkg::CNT_W'(idx_q + 1'b1);
					end
				end
			end
			S_DISP: begin
				if (slot_free) begin
					res_load      = 1'b1;
					res_d.status  = clist_pkg::ST_OK;
					res_d.element = rdata;
					res_d.last    = last_one;
					if (last_one) begin
						state_d = S_IDLE;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = clist_pkg::ptr_inc(cur_q);
						cur_d      = clist_pkg::ptr_inc(cur_q);
						idx_d      = clist_pkg::CNT_W'(idx_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		idx_q <= idx_d;
		key_q <= key_d;
	end

	assign stat.busy  = (state_q != S_IDLE);
	assign stat.count = count_q;

endmodule

[rtl/circular_list_engine_core.sv]
// Top level of the circular list engine: sequencer, list RAM and result register.
//
// Keeps an ordered list of up to CAPACITY (16) signed 32-bit values in a
// circular buffer RAM addressed by head and tail pointers. One command beat
// is taken at a time. Insert at end or beginning writes the RAM directly;
// a full list refuses the insert with status full. Delete walks the list
// from the head through the RAM read port, one entry per cycle while the
// result side does not stall, and on a hit closes the gap by moving each
// later entry one place toward the head, again one entry per cycle; every
// entry is either searched or moved once after the head read, whether the
// delete hits or misses. Display reads the head, then streams one result
// beat per cycle while the result side does not stall. Delete and display
// on an empty list answer with status empty. The registered RAM read sets
// the walk to one entry per cycle. Results leave through an output register;
// a new command is taken only while the sequencer is idle and that register
// is free or draining.
// Stalls on the result side pause the walk without losing or repeating beats.
`include "assert_macros.svh"

module circular_list_engine_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  clist_pkg::cmd_t  cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output clist_pkg::res_t  res
);

	clist_pkg::mem_req_t          mreq;
	clist_pkg::ctrl_stat_t        stat;
	clist_pkg::res_t              res_d;
	clist_pkg::res_t              res_q;
	logic [clist_pkg::DATA_W-1:0] rdata;
	logic                         res_load;
	logic                         res_valid_q;
	logic                         slot_free;

	// output register can take a new beat when empty or being taken now
	assign slot_free = !res_valid_q || !res_stall;

	clist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.slot_free (slot_free),
		.res_load  (res_load),
		.res_d     (res_d),
		.mreq      (mreq),
		.rdata     (rdata),
		.stat      (stat)
	);

	clist_ram #(
		.DEPTH (clist_pkg::CAPACITY),
		.WIDTH (clist_pkg::DATA_W),
		.AW    (clist_pkg::PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (rdata)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`CLE_ASSERT_NEVER(a_count_range, clk, arst_n, stat.count > clist_pkg::CNT_W'(clist_pkg::CAPACITY), "entry count above capacity")
	`CLE_ASSERT_NEVER(a_no_overwrite, clk, arst_n, res_valid_q && res_stall && res_load, "result beat overwritten while stalled")
	`CLE_ASSERT(a_accept_idle, clk, arst_n, (cmd_valid && !cmd_stall) |-> !stat.busy, "command taken while busy")
	`CLE_ASSERT(a_err_is_last, clk, arst_n, (res_valid && res.status != clist_pkg::ST_OK) |-> res.last, "error beat without last")

endmodule
